@@ rtl/msl_pkg.sv @@
package msl_pkg;

   localparam int MAX_BOOKS   = 1024;
   localparam int MAX_SHELVES = 64;
   localparam int BOOK_W      = 11;
   localparam int SHELF_W     = 7;
   localparam int CMD_W       = 3;
   localparam int STAT_W      = 2;
   localparam int LINK_AW     = $clog2(MAX_BOOKS);
   localparam int SHELF_AW    = $clog2(MAX_SHELVES);

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT      = 3'd0,
      CMD_HEAD_BACK = 3'd1,
      CMD_TAIL_FRONT = 3'd2,
      CMD_SPLICE_BEF = 3'd3,
      CMD_SPLICE_AFT = 3'd4,
      CMD_QUERY_LIST = 3'd5,
      CMD_QUERY_NEXT = 3'd6,
      CMD_BAD       = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_SAME  = 2'd2,
      STAT_RANGE = 2'd3
   } stat_type;

   typedef struct packed {
      logic [BOOK_W-1:0] first;
      logic [BOOK_W-1:0] last;
      logic [BOOK_W-1:0] size;
   } shelf_ent_type;

   typedef struct packed {
      logic               clear_all;
      logic               wr_en;
      logic [SHELF_AW-1:0] wr_addr;
      shelf_ent_type      wr_data;
      logic [SHELF_AW-1:0] rd_addr;
   } shelf_ctl_type;

   typedef struct packed {
      logic               en;
      logic [LINK_AW-1:0] addr;
      logic [BOOK_W-1:0]  data;
   } link_wr_type;

endpackage

@@ rtl/msl_shelf_tbl.sv @@
module msl_shelf_tbl
   import msl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  shelf_ctl_type ctl,
   output shelf_ent_type rd_data
);

   shelf_ent_type mem [MAX_SHELVES];
   logic [MAX_SHELVES-1:0] vld_ff, vld_in;
   shelf_ent_type q_ff;
   logic vq_ff;

   always_comb begin
      vld_in = vld_ff;
      if (ctl.clear_all) begin
         vld_in = '0;
      end
      if (ctl.wr_en) begin
         vld_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         vq_ff  <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         vq_ff  <= vld_ff[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      q_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = vq_ff ? q_ff : '0;

endmodule

@@ rtl/multi_shelf_list_manager_unit.sv @@
// channel | ports                                   | direction
// req     | req_valid, req_stall, cmd/shelves/book  | in
// rsp     | rsp_valid, rsp_stall, status/books/links | out
// csr     | csr_write, csr_index, csr_wdata         | in
// Results leave via ST_RESP: rejected directly, queries after their reads, empty or same list
// after ST_EVAL, moves and splices after two shelf reads, one link read and two writes.
// Init answers after the link sweep over the saturated book_count and the shelf write.
// Reset empties every list at once; link memories are not cleared.
// A finished transfer waits in the output register while the next command runs.
module multi_shelf_list_manager_unit
   import msl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [SHELF_W-1:0] req_source_shelf,
   input  logic [SHELF_W-1:0] req_dest_shelf,
   input  logic [BOOK_W-1:0]  req_book,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [BOOK_W-1:0]  rsp_shelf_books,
   output logic [BOOK_W-1:0]  rsp_first_book,
   output logic [BOOK_W-1:0]  rsp_last_book,
   output logic [BOOK_W-1:0]  rsp_next_book,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [BOOK_W-1:0]  csr_wdata
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_SWEEP   = 12'b0000_0000_0010,
      ST_INIT_SH = 12'b0000_0000_0100,
      ST_RD_S    = 12'b0000_0000_1000,
      ST_RD_D    = 12'b0000_0001_0000,
      ST_EVAL    = 12'b0000_0010_0000,
      ST_LINK    = 12'b0000_0100_0000,
      ST_WR_A    = 12'b0000_1000_0000,
      ST_WR_B    = 12'b0001_0000_0000,
      ST_NRD     = 12'b0010_0000_0000,
      ST_NQ      = 12'b0100_0000_0000,
      ST_RESP    = 12'b1000_0000_0000
   } state_type;

   localparam logic [BOOK_W-1:0] MaxBooks = BOOK_W'(MAX_BOOKS);
   localparam logic [SHELF_W-1:0] MaxShelves = SHELF_W'(MAX_SHELVES);

   state_type state_ff, state_in;
   logic [BOOK_W-1:0]  book_count_ff;
   logic [SHELF_W-1:0] shelf_total_ff;
   cmd_type            cmd_ff;
   logic [SHELF_W-1:0] src_ff, dst_ff;
   logic [BOOK_W-1:0]  book_ff, n_ff, k_ff, k_in;
   shelf_ent_type      s_ent_ff, s_ent_in, d_ent_ff, d_ent_in, sp_ff, sp_in;
   stat_type           res_stat_ff, res_stat_in;
   shelf_ent_type      res_ent_ff, res_ent_in;
   logic [BOOK_W-1:0]  res_next_ff, res_next_in;
   link_wr_type        nwa_ff, nwa_in, nwb_ff, nwb_in, pwa_ff, pwa_in, pwb_ff, pwb_in;
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   shelf_ent_type      rsp_ent_ff;
   logic [BOOK_W-1:0]  rsp_next_ff;

   logic [BOOK_W-1:0] next_mem [MAX_BOOKS];
   logic [BOOK_W-1:0] prev_mem [MAX_BOOKS];
   logic [BOOK_W-1:0] next_q_ff, prev_q_ff;
   logic [LINK_AW-1:0] lrd_addr;
   link_wr_type nw, pw;

   shelf_ctl_type sh_ctl;
   shelf_ent_type sh_q;

   logic accept, out_free, src_ok, dst_ok, book_ok;
   logic [BOOK_W-1:0] n_sat, b, nb;
   shelf_ent_type d0, dn;

   msl_shelf_tbl u_shelf_tbl (
      .clock   (clock),
      .reset   (reset),
      .ctl     (sh_ctl),
      .rd_data (sh_q)
   );

   function automatic logic [LINK_AW-1:0] lidx(input logic [BOOK_W-1:0] x);
      logic [BOOK_W-1:0] t;
      t = x - BOOK_W'(1);
      return t[LINK_AW-1:0];
   endfunction

   function automatic logic [SHELF_AW-1:0] sidx(input logic [SHELF_W-1:0] x);
      logic [SHELF_W-1:0] t;
      t = x - SHELF_W'(1);
      return t[SHELF_AW-1:0];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign src_ok  = (req_source_shelf != '0) && (req_source_shelf <= shelf_total_ff)
                    && (req_source_shelf <= MaxShelves);
   assign dst_ok  = (req_dest_shelf != '0) && (req_dest_shelf <= shelf_total_ff)
                    && (req_dest_shelf <= MaxShelves);
   assign book_ok = (req_book != '0) && (req_book <= MaxBooks);
   assign n_sat   = (book_count_ff > MaxBooks) ? MaxBooks : book_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         book_count_ff  <= MaxBooks;
         shelf_total_ff <= MaxShelves;
      end else if (csr_write) begin
         if (csr_index == 1'b0) begin
            book_count_ff <= csr_wdata;
         end else begin
            shelf_total_ff <= csr_wdata[SHELF_W-1:0];
         end
      end
   end

   // link update plan for moves and splices
   always_comb begin
      b     = (cmd_ff == CMD_HEAD_BACK) ? s_ent_ff.last : s_ent_ff.last;
      nb    = '0;
      sp_in = '0;
      d0    = d_ent_ff;
      dn    = d_ent_ff;
      nwa_in = '0;
      nwb_in = '0;
      pwa_in = '0;
      pwb_in = '0;
      case (cmd_ff)
         CMD_HEAD_BACK: begin
            b  = s_ent_ff.first;
            nb = next_q_ff;
            sp_in.first = nb;
            sp_in.last  = (nb != '0) ? s_ent_ff.last : '0;
            sp_in.size  = s_ent_ff.size - BOOK_W'(1);
            d0 = (src_ff == dst_ff) ? sp_in : d_ent_ff;
            nwa_in = '{en: 1'b1, addr: lidx(b), data: '0};
            pwa_in = '{en: (nb != '0), addr: lidx(nb), data: '0};
            if (d0.first == '0) begin
               dn.first = b;
               pwb_in = '{en: 1'b1, addr: lidx(b), data: '0};
            end else begin
               dn.first = d0.first;
               pwb_in = '{en: 1'b1, addr: lidx(b), data: d0.last};
               nwb_in = '{en: 1'b1, addr: lidx(d0.last), data: b};
            end
            dn.last = b;
            dn.size = d0.size + BOOK_W'(1);
         end
         CMD_TAIL_FRONT: begin
            b  = s_ent_ff.last;
            nb = prev_q_ff;
            sp_in.last  = nb;
            sp_in.first = (nb != '0) ? s_ent_ff.first : '0;
            sp_in.size  = s_ent_ff.size - BOOK_W'(1);
            d0 = (src_ff == dst_ff) ? sp_in : d_ent_ff;
            pwa_in = '{en: 1'b1, addr: lidx(b), data: '0};
            nwa_in = '{en: (nb != '0), addr: lidx(nb), data: '0};
            nwb_in = '{en: 1'b1, addr: lidx(b), data: d0.first};
            pwb_in = '{en: (d0.first != '0), addr: lidx(d0.first), data: b};
            dn.first = b;
            dn.last  = (d0.first == '0) ? b : d0.last;
            dn.size  = d0.size + BOOK_W'(1);
         end
         CMD_SPLICE_BEF, CMD_SPLICE_AFT: begin
            dn.size = d_ent_ff.size + s_ent_ff.size;
            if (d_ent_ff.first == '0) begin
               dn.first = s_ent_ff.first;
               dn.last  = s_ent_ff.last;
            end else if (cmd_ff == CMD_SPLICE_BEF) begin
               nwa_in = '{en: 1'b1, addr: lidx(s_ent_ff.last), data: d_ent_ff.first};
               pwa_in = '{en: 1'b1, addr: lidx(d_ent_ff.first), data: s_ent_ff.last};
               dn.first = s_ent_ff.first;
            end else begin
               pwa_in = '{en: 1'b1, addr: lidx(s_ent_ff.first), data: d_ent_ff.last};
               nwa_in = '{en: 1'b1, addr: lidx(d_ent_ff.last), data: s_ent_ff.first};
               dn.last = s_ent_ff.last;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      s_ent_in    = s_ent_ff;
      d_ent_in    = d_ent_ff;
      res_stat_in = res_stat_ff;
      res_ent_in  = res_ent_ff;
      res_next_in = res_next_ff;
      sh_ctl      = '0;
      lrd_addr    = lidx(book_ff);
      nw          = '0;
      pw          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_stat_in = STAT_RANGE;
               res_ent_in  = '0;
               res_next_in = '0;
               state_in    = ST_RESP;
               case (cmd_type'(req_cmd))
                  CMD_INIT: begin
                     sh_ctl.clear_all = 1'b1;
                     k_in     = BOOK_W'(1);
                     state_in = (n_sat == '0) ? ST_INIT_SH : ST_SWEEP;
                  end
                  CMD_QUERY_LIST: begin
                     if (src_ok) state_in = ST_RD_S;
                  end
                  CMD_QUERY_NEXT: begin
                     if (book_ok) state_in = ST_NRD;
                  end
                  CMD_HEAD_BACK, CMD_TAIL_FRONT, CMD_SPLICE_BEF, CMD_SPLICE_AFT: begin
                     if (src_ok && dst_ok) state_in = ST_RD_S;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            nw = '{en: 1'b1, addr: lidx(k_ff),
                   data: (k_ff < n_ff) ? k_ff + BOOK_W'(1) : '0};
            pw = '{en: 1'b1, addr: lidx(k_ff), data: k_ff - BOOK_W'(1)};
            k_in = k_ff + BOOK_W'(1);
            if (k_ff == n_ff) state_in = ST_INIT_SH;
         end
         ST_INIT_SH: begin
            sh_ctl.wr_en   = 1'b1;
            sh_ctl.wr_addr = '0;
            sh_ctl.wr_data = '{first: (n_ff != '0) ? BOOK_W'(1) : '0,
                               last: n_ff, size: n_ff};
            res_stat_in = STAT_DONE;
            res_ent_in  = sh_ctl.wr_data;
            state_in    = ST_RESP;
         end
         ST_RD_S: begin
            sh_ctl.rd_addr = sidx(src_ff);
            state_in = ST_RD_D;
         end
         ST_RD_D: begin
            sh_ctl.rd_addr = sidx(dst_ff);
            s_ent_in = sh_q;
            if (cmd_ff == CMD_QUERY_LIST) begin
               res_stat_in = STAT_DONE;
               res_ent_in  = sh_q;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            d_ent_in = sh_q;
            lrd_addr = lidx((cmd_ff == CMD_HEAD_BACK) ? s_ent_ff.first : s_ent_ff.last);
            res_ent_in = sh_q;
            if (s_ent_ff.first == '0) begin
               res_stat_in = STAT_EMPTY;
               state_in    = ST_RESP;
            end else if ((cmd_ff == CMD_SPLICE_BEF || cmd_ff == CMD_SPLICE_AFT)
                         && src_ff == dst_ff) begin
               res_stat_in = STAT_SAME;
               state_in    = ST_RESP;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            res_stat_in = STAT_DONE;
            res_ent_in  = dn;
            state_in    = ST_WR_A;
         end
         ST_WR_A: begin
            sh_ctl.wr_en   = 1'b1;
            sh_ctl.wr_addr = sidx(src_ff);
            sh_ctl.wr_data = sp_ff;
            nw = nwa_ff;
            pw = pwa_ff;
            state_in = ST_WR_B;
         end
         ST_WR_B: begin
            sh_ctl.wr_en   = 1'b1;
            sh_ctl.wr_addr = sidx(dst_ff);
            sh_ctl.wr_data = res_ent_ff;
            nw = nwb_ff;
            pw = pwb_ff;
            state_in = ST_RESP;
         end
         ST_NRD: begin
            state_in = ST_NQ;
         end
         ST_NQ: begin
            res_stat_in = STAT_DONE;
            res_next_in = next_q_ff;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_cmd);
         src_ff  <= req_source_shelf;
         dst_ff  <= req_dest_shelf;
         book_ff <= req_book;
         n_ff    <= n_sat;
      end
      k_ff        <= k_in;
      s_ent_ff    <= s_ent_in;
      d_ent_ff    <= d_ent_in;
      res_stat_ff <= res_stat_in;
      res_ent_ff  <= res_ent_in;
      res_next_ff <= res_next_in;
      if (state_ff == ST_LINK) begin
         sp_ff  <= sp_in;
         nwa_ff <= nwa_in;
         nwb_ff <= nwb_in;
         pwa_ff <= pwa_in;
         pwb_ff <= pwb_in;
      end
      if (state_ff == ST_RESP && out_free) begin
         rsp_status_ff <= res_stat_ff;
         rsp_ent_ff    <= res_ent_ff;
         rsp_next_ff   <= res_next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (nw.en) begin
         next_mem[nw.addr] <= nw.data;
      end
      if (pw.en) begin
         prev_mem[pw.addr] <= pw.data;
      end
      next_q_ff <= next_mem[lrd_addr];
      prev_q_ff <= prev_mem[lrd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_shelf_books = rsp_ent_ff.size;
   assign rsp_first_book  = rsp_ent_ff.first;
   assign rsp_last_book   = rsp_ent_ff.last;
   assign rsp_next_book   = rsp_next_ff;

endmodule
